### rtl/core/nntb_pkg.sv
// Shared types and constants for the nearest-neighbor tour builder.
package nntb_pkg;

   localparam int MAX_POINTS  = 512;
   localparam int COORD_BITS  = 16;
   localparam int IDX_BITS    = $clog2(MAX_POINTS);
   localparam int CNT_BITS    = $clog2(MAX_POINTS + 2);
   localparam int DIST_BITS   = 2 * COORD_BITS + 1;
   localparam int SQ_BITS     = 2 * COORD_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Port payload widths.
   localparam int OP_BITS       = 2;
   localparam int PORT_COORD    = 16;
   localparam int STATUS_BITS   = 3;
   localparam int TOUR_BITS     = 9;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 48;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - TOUR_BITS - 2 * PORT_COORD;

   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_STEP  = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_STORED  = 3'd0,
      STAT_REJECT  = 3'd1,
      STAT_POINT   = 3'd2,
      STAT_CLOSE   = 3'd3,
      STAT_OVER    = 3'd4,
      STAT_CLEARED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_LOAD,
      CMD_STEP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } cmd_type;

   typedef struct packed {
      logic                  visited;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } point_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_DRAIN
   } back_state_type;

endpackage

### rtl/core/nearest_neighbor_tour_builder.sv
// Top level of the greedy nearest-neighbor tour builder.
//
// Requests enter on req_*: tuser carries the op (clear, load, step), tdata the
// x and y of a point to load. An unknown op is taken and produces no response.
// Every other request produces exactly one response on rsp_*, in order, with
// the status in tuser and the point index and coordinates in tdata.
// Requests go into a four-entry queue, so the input keeps accepting while the
// tour engine is busy or a response waits; req_tready drops only when the
// queue is full. A response sits in an output register until rsp_tready takes
// it, and the engine holds its next request until that register frees up.
// Clear, load and a step that finds the store empty or the tour over put their
// response into the output register as the request is taken. The first step
// and the closing step pass through a fetch state, as they read point 0 from
// the memory. A middle step scans: the engine reads the point memory one entry
// per cycle through its single read port and compares each against the current
// point. Up to 512 points are held.
// Reset empties the queue and the point set and ends any tour; point storage
// itself is not cleared, as only loaded entries are ever read.
module nearest_neighbor_tour_builder
   import nntb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [OP_BITS-1:0]       req_tuser,  // op
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // x_in, y_in
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [STATUS_BITS-1:0]   rsp_tuser,  // status
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // tour_index, x_out, y_out, zero pad
);

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   nntb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   nntb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/nntb_front.sv
// Request decoder and command queue feeding the tour engine.
module nntb_front
   import nntb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [OP_BITS-1:0]       req_tuser,  // op
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // x_in, y_in
   output logic                     q_valid,
   output cmd_type                  q_cmd,
   input  logic                     q_pop
);

   cmd_type              fifo_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] fill_ff;
   logic [QCNT_BITS-1:0] fill_in;
   logic                 push;
   logic                 known_op;
   cmd_type              cmd_in;

   assign req_tready = (fill_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign q_valid    = (fill_ff != '0);
   assign q_cmd      = fifo_ff[rd_ptr_ff];

   // Unknown ops are taken and dropped: they produce no response.
   always_comb begin
      known_op    = 1'b1;
      cmd_in.kind = CMD_CLEAR;
      cmd_in.x    = req_tdata[COORD_BITS-1:0];
      cmd_in.y    = req_tdata[PORT_COORD +: COORD_BITS];
      case (req_tuser)
         OP_CLEAR: cmd_in.kind = CMD_CLEAR;
         OP_LOAD:  cmd_in.kind = CMD_LOAD;
         OP_STEP:  cmd_in.kind = CMD_STEP;
         default:  known_op = 1'b0;
      endcase
   end

   assign push = req_tvalid && req_tready && known_op;

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + QCNT_BITS'(1);
      end else if (!push && q_pop) begin
         fill_in = fill_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/core/nntb_back.sv
// Tour engine: point memory, nearest-neighbor scan and response register.
module nntb_back
   import nntb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  cmd_type                  q_cmd,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [STATUS_BITS-1:0]   rsp_tuser,  // status
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // tour_index, x_out, y_out, zero pad
);

   point_type             mem [MAX_POINTS];
   point_type             rd_data_ff;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic [CNT_BITS-1:0]   steps_ff;
   logic [CNT_BITS-1:0]   steps_in;
   logic                  close_ff;
   logic                  close_in;
   logic [IDX_BITS-1:0]   j_ff;
   logic [IDX_BITS-1:0]   j_in;
   logic [COORD_BITS-1:0] cur_x_ff;
   logic [COORD_BITS-1:0] cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff;
   logic [COORD_BITS-1:0] cur_y_in;

   // Scan pipeline.
   logic                  s1_v_ff;
   logic [IDX_BITS-1:0]   s1_j_ff;
   logic                  s2_v_ff;
   logic [IDX_BITS-1:0]   s2_j_ff;
   point_type             s2_pt_ff;
   logic [SQ_BITS-1:0]    sqx_ff;
   logic [SQ_BITS-1:0]    sqy_ff;
   logic                  found_ff;
   logic [DIST_BITS-1:0]  best_d_ff;
   logic [IDX_BITS-1:0]   best_j_ff;
   logic [COORD_BITS-1:0] best_x_ff;
   logic [COORD_BITS-1:0] best_y_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [IDX_BITS-1:0]   rsp_index_ff;
   logic [COORD_BITS-1:0] rsp_x_ff;
   logic [COORD_BITS-1:0] rsp_y_ff;

   logic                  out_free;
   logic                  pipe_empty;
   logic                  last_j;
   logic                  scan_start;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   point_type             wr_data;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  res_load;
   status_type            res_status;
   logic [IDX_BITS-1:0]   res_index;
   logic [COORD_BITS-1:0] res_x;
   logic [COORD_BITS-1:0] res_y;
   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic [DIST_BITS-1:0]  cand_d;
   logic                  better;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pipe_empty = !s1_v_ff && !s2_v_ff;
   assign last_j     = (CNT_BITS'(j_ff) + CNT_BITS'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free && q_cmd.kind == CMD_STEP &&
                count_ff != '0 && steps_ff <= count_ff) begin
               if (steps_ff == '0 || steps_ff == count_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FETCH: state_in = ST_IDLE;
         ST_SCAN: begin
            if (last_j) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_addr    = j_ff;
      res_load   = 1'b0;
      res_status = STAT_OVER;
      res_index  = '0;
      res_x      = '0;
      res_y      = '0;
      count_in   = count_ff;
      steps_in   = steps_ff;
      close_in   = close_ff;
      j_in       = j_ff;
      scan_start = 1'b0;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  CMD_CLEAR: begin
                     count_in   = '0;
                     steps_in   = '0;
                     res_load   = 1'b1;
                     res_status = STAT_CLEARED;
                  end
                  CMD_LOAD: begin
                     res_load = 1'b1;
                     if (count_ff == CNT_BITS'(MAX_POINTS) || steps_ff != '0) begin
                        res_status = STAT_REJECT;
                     end else begin
                        // A fresh entry starts unvisited, so a clear never has
                        // to sweep the marks.
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[IDX_BITS-1:0];
                        wr_data    = '{visited: 1'b0, y: q_cmd.y, x: q_cmd.x};
                        res_status = STAT_STORED;
                        res_index  = count_ff[IDX_BITS-1:0];
                        res_x      = q_cmd.x;
                        res_y      = q_cmd.y;
                        count_in   = count_ff + CNT_BITS'(1);
                     end
                  end
                  CMD_STEP: begin
                     if (count_ff == '0 || steps_ff > count_ff) begin
                        res_load   = 1'b1;
                        res_status = STAT_OVER;
                     end else if (steps_ff == '0 || steps_ff == count_ff) begin
                        close_in = (steps_ff != '0);
                     end else begin
                        j_in       = '0;
                        scan_start = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            res_load  = 1'b1;
            res_index = '0;
            res_x     = rd_data_ff.x;
            res_y     = rd_data_ff.y;
            steps_in  = steps_ff + CNT_BITS'(1);
            if (close_ff) begin
               res_status = STAT_CLOSE;
            end else begin
               res_status = STAT_POINT;
               wr_en      = 1'b1;
               wr_addr    = '0;
               wr_data    = '{visited: 1'b1, y: rd_data_ff.y, x: rd_data_ff.x};
               cur_x_in   = rd_data_ff.x;
               cur_y_in   = rd_data_ff.y;
            end
         end
         ST_SCAN: begin
            rd_addr = j_ff;
            j_in    = j_ff + IDX_BITS'(1);
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               res_load   = 1'b1;
               res_status = STAT_POINT;
               res_index  = best_j_ff;
               res_x      = best_x_ff;
               res_y      = best_y_ff;
               wr_en      = 1'b1;
               wr_addr    = best_j_ff;
               wr_data    = '{visited: 1'b1, y: best_y_ff, x: best_x_ff};
               cur_x_in   = best_x_ff;
               cur_y_in   = best_y_ff;
               steps_in   = steps_ff + CNT_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Distance terms for the entry that the memory returned this cycle.
   assign dx = (cur_x_ff >= rd_data_ff.x) ? cur_x_ff - rd_data_ff.x : rd_data_ff.x - cur_x_ff;
   assign dy = (cur_y_ff >= rd_data_ff.y) ? cur_y_ff - rd_data_ff.y : rd_data_ff.y - cur_y_ff;

   assign cand_d = DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);
   assign better = s2_v_ff && !s2_pt_ff.visited && (!found_ff || cand_d < best_d_ff);

   always_ff @(posedge clock) begin
      s1_j_ff  <= j_ff;
      s2_j_ff  <= s1_j_ff;
      s2_pt_ff <= rd_data_ff;
      sqx_ff   <= dx * dx;
      sqy_ff   <= dy * dy;
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      j_ff     <= j_in;
      close_ff <= close_in;
      if (better) begin
         best_d_ff <= cand_d;
         best_j_ff <= s2_j_ff;
         best_x_ff <= s2_pt_ff.x;
         best_y_ff <= s2_pt_ff.y;
      end
      if (res_load) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_x_ff      <= res_x;
         rsp_y_ff      <= res_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         steps_ff <= steps_in;
         s1_v_ff  <= (state_ff == ST_SCAN);
         s2_v_ff  <= s1_v_ff;
         if (scan_start) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {RSP_PAD_BITS'(0), PORT_COORD'(rsp_y_ff), PORT_COORD'(rsp_x_ff),
                        TOUR_BITS'(rsp_index_ff)};

`ifndef SYNTHESIS
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= count_ff + CNT_BITS'(1))
      else $error("tour step count ran past point count plus one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count exceeds store size");

   a_busy_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response register busy while a step is in progress");

   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && pipe_empty) |-> found_ff)
      else $error("scan finished without an unvisited point");
`endif

endmodule
